@@ rtl/sorted_entry_list_engine_defines.svh @@
// Assertion macros for the sorted entry list engine
`ifndef SORTED_ENTRY_LIST_ENGINE_DEFINES_SVH
`define SORTED_ENTRY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define SEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define SEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sel_pkg.sv @@
// Shared types, constants and helper functions for the sorted entry list engine
package sel_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ID_W    = 64;
    localparam int KEY_W   = 63;
    localparam int FUNC_W  = 3;
    localparam int ROW_W   = 6;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    typedef logic [CAPACITY-1:0] vec_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_UPDATE = 3'd2,
        FUNC_READ   = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [KEY_W-1:0]       key;
        logic                   pin;
    } entry_t;

    // per-cell compare results against the broadcast entry
    typedef struct packed {
        logic match;   // occupied and same id
        logic ahead;   // broadcast entry goes before this one, or row is free
        logic behind;  // occupied and broadcast entry goes after this one
    } flags_t;

    typedef struct packed {
        logic load_new;  // take the broadcast entry
        logic from_lo;   // take the entry of the row above (index - 1)
        logic from_hi;   // take the entry of the row below (index + 1)
    } cell_ctl_t;

    // bit i set when any of bits 0..i is set; log-depth prefix
    function automatic vec_t prefix_or(input vec_t v);
        vec_t acc;
        acc = v;
        for (int s = 0; s < IDX_W; s++) begin
            acc = acc | (acc << (1 << s));
        end
        return acc;
    endfunction

    // index of the set bit of a one-hot vector
    function automatic logic [IDX_W-1:0] encode(input vec_t v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (v[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/sel_cell.sv @@
// One row of the sorted list: stored entry, compare against broadcast, neighbor shift
module sel_cell (
    input  logic               aclk,
    input  sel_pkg::entry_t    bcast,
    input  logic               occ,
    input  sel_pkg::cell_ctl_t ctl,
    input  sel_pkg::entry_t    lo_data,
    input  sel_pkg::entry_t    hi_data,
    output sel_pkg::entry_t    data,
    output sel_pkg::flags_t    flags
);

    sel_pkg::entry_t data_reg;
    sel_pkg::entry_t data_next;
    sel_pkg::flags_t flags_reg;
    sel_pkg::flags_t flags_next;

    logic key_gt;
    logic key_eq;
    logic id_eq;
    logic id_lt;

    always_comb begin
        key_gt = bcast.key > data_reg.key;
        key_eq = bcast.key == data_reg.key;
        id_eq  = bcast.id == data_reg.id;
        id_lt  = $signed(bcast.id) < $signed(data_reg.id);

        flags_next.match  = occ && id_eq;
        flags_next.ahead  = !occ || key_gt || (key_eq && !id_lt);
        flags_next.behind = occ && !key_gt && !(key_eq && !id_lt);
    end

    always_comb begin
        data_next = data_reg;
        if (ctl.load_new) begin
            data_next = bcast;
        end else if (ctl.from_lo) begin
            data_next = lo_data;
        end else if (ctl.from_hi) begin
            data_next = hi_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        flags_reg <= flags_next;
    end

    assign data  = data_reg;
    assign flags = flags_reg;

endmodule

@@ rtl/sorted_entry_list_engine.sv @@
// The accepted item is registered, then comes a compare cycle in which every cell
// checks the broadcast entry in parallel, then a shift cycle in which cells move
// and the result is registered; a new item can be accepted in that shift cycle.
// A waiting result holds the shift cycle and the input until the result is taken.
// Reset (aresetn low, synchronous): entry count to zero, no item pending;
// row contents are not cleared and need no clearing pass.
module sorted_entry_list_engine (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [sel_pkg::FUNC_W-1:0]            s_func,
    input  logic signed [sel_pkg::ID_W-1:0]       s_entry_id,
    input  logic [sel_pkg::KEY_W-1:0]             s_sort_key,
    input  logic                                  s_pinned,
    input  logic [sel_pkg::ROW_W-1:0]             s_row,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [sel_pkg::STAT_W-1:0]            m_status,
    output logic [sel_pkg::POS_W-1:0]             m_position,
    output logic [sel_pkg::COUNT_W-1:0]           m_count,
    output logic signed [sel_pkg::ID_W-1:0]       m_row_id,
    output logic [sel_pkg::KEY_W-1:0]             m_row_key,
    output logic                                  m_row_pinned
);

    `include "sorted_entry_list_engine_defines.svh"

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_MOVE} state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic [sel_pkg::CNT_W-1:0] count_reg, count_next;

    sel_pkg::status_t            status_reg, status_next;
    logic [sel_pkg::POS_W-1:0]   pos_reg, pos_next;
    sel_pkg::entry_t             row_reg, row_next;

    sel_pkg::func_t              op_func_reg;
    sel_pkg::entry_t             op_entry_reg;
    logic [sel_pkg::ROW_W-1:0]   op_row_reg;

    logic accept;
    logic go;
    logic full;
    logic found;
    logic any_up;
    logic rd_hit;

    sel_pkg::vec_t occ, hit, pre, first, ahead, behind;
    sel_pkg::vec_t up_run, dn_run, ins_new, up_new, dn_new;
    sel_pkg::vec_t new_vec, lo_vec, hi_vec;

    sel_pkg::entry_t    cell_data [sel_pkg::CAPACITY];
    sel_pkg::flags_t    cell_flags[sel_pkg::CAPACITY];
    sel_pkg::cell_ctl_t cell_ctl  [sel_pkg::CAPACITY];
    sel_pkg::entry_t    rd_data;

    // shift cycle proceeds when the result register is free or being drained
    assign go     = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == S_IDLE) || (state_reg == S_MOVE && go);
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_func_reg      <= sel_pkg::func_t'(s_func);
            op_entry_reg.id  <= s_entry_id;
            op_entry_reg.key <= s_sort_key;
            op_entry_reg.pin <= s_pinned;
            op_row_reg       <= s_row;
        end
    end

    // row of cells
    for (genvar g = 0; g < sel_pkg::CAPACITY; g++) begin : g_cell
        sel_pkg::entry_t lo_d;
        sel_pkg::entry_t hi_d;

        assign occ[g]    = sel_pkg::CNT_W'(g) < count_reg;
        assign hit[g]    = cell_flags[g].match;
        assign ahead[g]  = cell_flags[g].ahead;
        assign behind[g] = cell_flags[g].behind;

        assign cell_ctl[g].load_new = go && (state_reg == S_MOVE) && new_vec[g];
        assign cell_ctl[g].from_lo  = go && (state_reg == S_MOVE) && lo_vec[g];
        assign cell_ctl[g].from_hi  = go && (state_reg == S_MOVE) && hi_vec[g];

        if (g == 0) begin : g_top
            assign lo_d = cell_data[g];
        end else begin : g_mid_lo
            assign lo_d = cell_data[g-1];
        end
        if (g == sel_pkg::CAPACITY - 1) begin : g_bot
            assign hi_d = cell_data[g];
        end else begin : g_mid_hi
            assign hi_d = cell_data[g+1];
        end

        sel_cell u_cell (
            .aclk    (aclk),
            .bcast   (op_entry_reg),
            .occ     (occ[g]),
            .ctl     (cell_ctl[g]),
            .lo_data (lo_d),
            .hi_data (hi_d),
            .data    (cell_data[g]),
            .flags   (cell_flags[g])
        );
    end

    // row-wide decode from the registered cell flags
    always_comb begin
        full  = count_reg >= sel_pkg::CNT_W'(sel_pkg::CAPACITY);
        pre   = sel_pkg::prefix_or(hit);
        first = pre & ~(pre << 1);
        found = pre[sel_pkg::CAPACITY-1];

        // list is sorted, so ahead is a run of ones from the insert point down
        ins_new = ahead & ~(ahead << 1);

        // update: rows above the match that the new key precedes
        up_run = ahead & ~pre;
        any_up = |up_run;
        up_new = up_run & ~(up_run << 1);
        // otherwise rows below the match that the new key follows
        dn_run = behind & pre & ~first;
        dn_new = (first | dn_run) & ~(dn_run >> 1);

        new_vec = '0;
        lo_vec  = '0;
        hi_vec  = '0;
        case (op_func_reg)
            sel_pkg::FUNC_INSERT: begin
                if (!full) begin
                    new_vec = ins_new;
                    lo_vec  = ahead << 1;
                end
            end
            sel_pkg::FUNC_REMOVE: begin
                if (found) begin
                    hi_vec = pre;
                end
            end
            sel_pkg::FUNC_UPDATE: begin
                if (found) begin
                    if (any_up) begin
                        new_vec = up_new;
                        lo_vec  = up_run << 1;
                    end else begin
                        new_vec = dn_new;
                        hi_vec  = dn_run >> 1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // read port mux
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < sel_pkg::CAPACITY; i++) begin
            if (i == int'(op_row_reg)) begin
                rd_data = cell_data[i];
            end
        end
        rd_hit = int'(op_row_reg) < int'(count_reg);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        row_next     = row_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_MOVE;
            end
            S_MOVE: begin
                if (go) begin
                    state_next   = accept ? S_CMP : S_IDLE;
                    m_valid_next = 1'b1;
                    status_next  = sel_pkg::STAT_OK;
                    pos_next     = '0;
                    row_next     = '0;
                    case (op_func_reg)
                        sel_pkg::FUNC_INSERT: begin
                            if (full) begin
                                status_next = sel_pkg::STAT_FULL;
                            end else begin
                                count_next = count_reg + sel_pkg::CNT_W'(1);
                                pos_next   = sel_pkg::POS_W'(sel_pkg::encode(new_vec));
                            end
                        end
                        sel_pkg::FUNC_REMOVE: begin
                            if (found) begin
                                count_next = count_reg - sel_pkg::CNT_W'(1);
                                pos_next   = sel_pkg::POS_W'(sel_pkg::encode(first));
                            end else begin
                                status_next = sel_pkg::STAT_NOT_FOUND;
                            end
                        end
                        sel_pkg::FUNC_UPDATE: begin
                            if (found) begin
                                pos_next = sel_pkg::POS_W'(sel_pkg::encode(new_vec));
                            end else begin
                                status_next = sel_pkg::STAT_NOT_FOUND;
                            end
                        end
                        sel_pkg::FUNC_READ: begin
                            pos_next = op_row_reg;
                            if (rd_hit) begin
                                row_next = rd_data;
                            end else begin
                                status_next = sel_pkg::STAT_NOT_FOUND;
                            end
                        end
                        sel_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                            status_next = sel_pkg::STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
            pos_reg     <= pos_next;
            row_reg     <= row_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_position   = pos_reg;
    assign m_count      = sel_pkg::COUNT_W'(count_reg);
    assign m_row_id     = row_reg.id;
    assign m_row_key    = row_reg.key;
    assign m_row_pinned = row_reg.pin;

    `SEL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= sel_pkg::CNT_W'(sel_pkg::CAPACITY), "count above capacity")
    `SEL_ASSERT_NOW(a_insert_onehot, state_reg == S_MOVE && op_func_reg == sel_pkg::FUNC_INSERT && !full, $onehot(new_vec), "insert point not unique")
    `SEL_ASSERT_NEXT(a_full_holds, state_reg == S_MOVE && go && op_func_reg == sel_pkg::FUNC_INSERT && full, count_reg == $past(count_reg), "count changed on full insert")
    `SEL_ASSERT_NOW(a_result_src, $rose(m_valid_reg), $past(state_reg) == S_MOVE, "result without shift cycle")

endmodule

@@ test/sorted_entry_list_engine_checker.sv @@
// Result checker for the sorted entry list engine: mirrors the sorted list and compares every result
`timescale 1ns / 100ps

module sorted_entry_list_engine_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [sel_pkg::FUNC_W-1:0]        s_func,
    input  logic signed [sel_pkg::ID_W-1:0]   s_entry_id,
    input  logic [sel_pkg::KEY_W-1:0]         s_sort_key,
    input  logic                              s_pinned,
    input  logic [sel_pkg::ROW_W-1:0]         s_row,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [sel_pkg::STAT_W-1:0]        m_status,
    input  logic [sel_pkg::POS_W-1:0]         m_position,
    input  logic [sel_pkg::COUNT_W-1:0]       m_count,
    input  logic signed [sel_pkg::ID_W-1:0]   m_row_id,
    input  logic [sel_pkg::KEY_W-1:0]         m_row_key,
    input  logic                              m_row_pinned,
    output int                                mismatches,
    output int                                outstanding,
    output int                                ok_seen,
    output int                                absent_seen,
    output int                                full_seen
);

    typedef struct packed {
        logic [sel_pkg::STAT_W-1:0]  status;
        logic [sel_pkg::POS_W-1:0]   position;
        logic [sel_pkg::COUNT_W-1:0] count;
        sel_pkg::entry_t             row;
    } outcome_t;

    sel_pkg::entry_t list_rows[sel_pkg::CAPACITY];
    int              list_fill = 0;
    outcome_t        pending_outcomes[$];
    int              results_seen = 0;

    // a belongs ahead of b: higher key first, on equal keys the larger or equal id
    function automatic bit ranks_ahead(input sel_pkg::entry_t a, input sel_pkg::entry_t b);
        if (a.key == b.key) begin
            return !($signed(a.id) < $signed(b.id));
        end
        return a.key > b.key;
    endfunction

    function automatic bit ranks_behind(input sel_pkg::entry_t a, input sel_pkg::entry_t b);
        if (a.key == b.key) begin
            return $signed(a.id) < $signed(b.id);
        end
        return a.key < b.key;
    endfunction

    // lowest occupied row holding the id, -1 when absent
    function automatic int locate_id(input logic signed [sel_pkg::ID_W-1:0] wanted);
        for (int i = 0; i < list_fill; i++) begin
            if (list_rows[i].id == wanted) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic outcome_t run_list_command(input logic [sel_pkg::FUNC_W-1:0] code,
                                                  input sel_pkg::entry_t item,
                                                  input logic [sel_pkg::ROW_W-1:0] pick);
        outcome_t        res;
        sel_pkg::entry_t moved;
        int              at;
        int              hit;
        res = '0;
        res.status = sel_pkg::STAT_OK;
        case (code)
            sel_pkg::FUNC_INSERT: begin
                if (list_fill >= sel_pkg::CAPACITY) begin
                    res.status = sel_pkg::STAT_FULL;
                end else begin
                    at = 0;
                    while (at < list_fill && !ranks_ahead(item, list_rows[at])) begin
                        at++;
                    end
                    for (int i = list_fill; i > at; i--) begin
                        list_rows[i] = list_rows[i-1];
                    end
                    list_rows[at] = item;
                    list_fill++;
                    res.position = sel_pkg::POS_W'(at);
                end
            end
            sel_pkg::FUNC_REMOVE: begin
                hit = locate_id(item.id);
                if (hit < 0) begin
                    res.status = sel_pkg::STAT_NOT_FOUND;
                end else begin
                    for (int i = hit; i < list_fill - 1; i++) begin
                        list_rows[i] = list_rows[i+1];
                    end
                    list_fill--;
                    res.position = sel_pkg::POS_W'(hit);
                end
            end
            sel_pkg::FUNC_UPDATE: begin
                hit = locate_id(item.id);
                if (hit < 0) begin
                    res.status = sel_pkg::STAT_NOT_FOUND;
                end else begin
                    moved = item;
                    at = hit;
                    while (at > 0 && ranks_ahead(moved, list_rows[at-1])) begin
                        at--;
                    end
                    // only try moving down when it did not move up
                    if (at == hit) begin
                        while (at + 1 < list_fill && ranks_behind(moved, list_rows[at+1])) begin
                            at++;
                        end
                    end
                    if (at < hit) begin
                        for (int i = hit; i > at; i--) begin
                            list_rows[i] = list_rows[i-1];
                        end
                    end else begin
                        for (int i = hit; i < at; i++) begin
                            list_rows[i] = list_rows[i+1];
                        end
                    end
                    list_rows[at] = moved;
                    res.position = sel_pkg::POS_W'(at);
                end
            end
            sel_pkg::FUNC_READ: begin
                res.position = pick;
                if (pick < list_fill) begin
                    res.row = list_rows[pick];
                end else begin
                    res.status = sel_pkg::STAT_NOT_FOUND;
                end
            end
            sel_pkg::FUNC_CLEAR: begin
                list_fill = 0;
            end
            default: begin
                res.status = sel_pkg::STAT_NOT_FOUND;
            end
        endcase
        res.count = sel_pkg::COUNT_W'(list_fill);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t: result %0d: %s is %h, expected %h",
                     $time, results_seen, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : watch
        outcome_t        got;
        outcome_t        want;
        sel_pkg::entry_t item;
        if (!aresetn) begin
            list_fill = 0;
            pending_outcomes.delete();
            mismatches  = 0;
            ok_seen     = 0;
            absent_seen = 0;
            full_seen   = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.status   = m_status;
                got.position = m_position;
                got.count    = m_count;
                got.row.id   = m_row_id;
                got.row.key  = m_row_key;
                got.row.pin  = m_row_pinned;
                results_seen++;
                case (got.status)
                    sel_pkg::STAT_OK:        ok_seen++;
                    sel_pkg::STAT_NOT_FOUND: absent_seen++;
                    sel_pkg::STAT_FULL:      full_seen++;
                    default: ;
                endcase
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("item with nothing outstanding, status",
                                    64'(got.status), '0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.position !== want.position)
                        report_mismatch("position", 64'(got.position), 64'(want.position));
                    if (got.count !== want.count)
                        report_mismatch("count", 64'(got.count), 64'(want.count));
                    if (got.row.id !== want.row.id)
                        report_mismatch("row_id", got.row.id, want.row.id);
                    if (got.row.key !== want.row.key)
                        report_mismatch("row_key", 64'(got.row.key), 64'(want.row.key));
                    if (got.row.pin !== want.row.pin)
                        report_mismatch("row_pinned", 64'(got.row.pin), 64'(want.row.pin));
                end
            end
            if (s_valid && s_ready) begin
                item.id  = s_entry_id;
                item.key = s_sort_key;
                item.pin = s_pinned;
                pending_outcomes.push_back(run_list_command(s_func, item, s_row));
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

@@ test/sorted_entry_list_engine_test.sv @@
// Testbench top for the sorted entry list engine: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module sorted_entry_list_engine_test;

    localparam int ITEM_TARGET = 1150;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 250000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [63:0] ID_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ID_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ID_NEG1 = 64'hffff_ffff_ffff_ffff;
    localparam logic [62:0] KEY_MAX = 63'h7fff_ffff_ffff_ffff;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [sel_pkg::FUNC_W-1:0]        s_func = '0;
    logic signed [sel_pkg::ID_W-1:0]   s_entry_id = '0;
    logic [sel_pkg::KEY_W-1:0]         s_sort_key = '0;
    logic                              s_pinned = 1'b0;
    logic [sel_pkg::ROW_W-1:0]         s_row = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic [sel_pkg::STAT_W-1:0]        m_status;
    logic [sel_pkg::POS_W-1:0]         m_position;
    logic [sel_pkg::COUNT_W-1:0]       m_count;
    logic signed [sel_pkg::ID_W-1:0]   m_row_id;
    logic [sel_pkg::KEY_W-1:0]         m_row_key;
    logic                              m_row_pinned;

    int mismatches;
    int outstanding;
    int ok_seen;
    int absent_seen;
    int full_seen;

    int          items_sent = 0;
    int          fill_rounds = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    logic [63:0] id_pool[16];

    always #4 aclk = ~aclk;

    sorted_entry_list_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_entry_id   (s_entry_id),
        .s_sort_key   (s_sort_key),
        .s_pinned     (s_pinned),
        .s_row        (s_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_position   (m_position),
        .m_count      (m_count),
        .m_row_id     (m_row_id),
        .m_row_key    (m_row_key),
        .m_row_pinned (m_row_pinned)
    );

    sorted_entry_list_engine_checker result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_entry_id   (s_entry_id),
        .s_sort_key   (s_sort_key),
        .s_pinned     (s_pinned),
        .s_row        (s_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_position   (m_position),
        .m_count      (m_count),
        .m_row_id     (m_row_id),
        .m_row_key    (m_row_key),
        .m_row_pinned (m_row_pinned),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .ok_seen      (ok_seen),
        .absent_seen  (absent_seen),
        .full_seen    (full_seen)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items sent", cycle_count, items_sent);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [62:0] pick_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: return 63'($urandom_range(0, 7));   // dense keys give plenty of ties
            2:    return $urandom_range(0, 1) ? KEY_MAX : 63'd0;
            default: return raw[62:0];
        endcase
    endfunction

    function automatic logic [63:0] pool_id();
        return id_pool[4'($urandom_range(0, 15))];
    endfunction

    // mostly reuse known ids so remove and update hit, sometimes a fresh one
    function automatic logic [63:0] insert_id();
        logic [63:0] fresh;
        if ($urandom_range(0, 3) != 0) begin
            return pool_id();
        end
        fresh = {$urandom, $urandom};
        id_pool[4'($urandom_range(4, 15))] = fresh;
        return fresh;
    endfunction

    task automatic offer_command(input logic [sel_pkg::FUNC_W-1:0] code,
                                 input logic [63:0] id, input logic [62:0] key,
                                 input logic pin, input logic [sel_pkg::ROW_W-1:0] pick);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_func     <= code;
        s_entry_id <= id;
        s_sort_key <= key;
        s_pinned   <= pin;
        s_row      <= pick;
        s_valid    <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic random_command();
        int dice;
        dice = $urandom_range(0, 99);
        if (dice < 40)
            offer_command(sel_pkg::FUNC_INSERT, insert_id(), pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (dice < 58)
            offer_command(sel_pkg::FUNC_REMOVE, pool_id(), pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (dice < 78)
            offer_command(sel_pkg::FUNC_UPDATE, pool_id(), pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (dice < 94)
            offer_command(sel_pkg::FUNC_READ, {$urandom, $urandom}, pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else if (dice < 95)
            offer_command(sel_pkg::FUNC_CLEAR, {$urandom, $urandom}, pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        else
            offer_command(3'($urandom_range(5, 7)), {$urandom, $urandom}, pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    endtask

    // clear, overfill past capacity, then work on the full list
    task automatic fill_list();
        offer_command(sel_pkg::FUNC_CLEAR, '0, '0, 1'b0, '0);
        repeat (sel_pkg::CAPACITY + 6)
            offer_command(sel_pkg::FUNC_INSERT, insert_id(), pick_key(),
                          1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        repeat ($urandom_range(15, 30)) random_command();
        fill_rounds++;
    endtask

    initial begin : receiver
        bit stall_done;
        stall_done = 1'b0;
        @(posedge aclk);
        forever begin
            if (!stall_done && items_sent > 400) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                stall_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin : stimulus
        id_pool[0] = ID_MAX;
        id_pool[1] = ID_MIN;
        id_pool[2] = '0;
        id_pool[3] = ID_NEG1;
        for (int i = 4; i < 16; i++) begin
            id_pool[i] = {$urandom, $urandom};
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list: every lookup misses
        offer_command(sel_pkg::FUNC_READ,   '0,     '0,      1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_REMOVE, '0,     '0,      1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_UPDATE, ID_MAX, KEY_MAX, 1'b1, 6'd0);
        // extremes, key ties, and a repeated id and key that goes ahead of the stored one
        offer_command(sel_pkg::FUNC_INSERT, ID_MAX, KEY_MAX, 1'b1, 6'd0);
        offer_command(sel_pkg::FUNC_INSERT, ID_MIN, '0,      1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_INSERT, '0,     KEY_MAX, 1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_INSERT, '0,     KEY_MAX, 1'b1, 6'd0);
        offer_command(sel_pkg::FUNC_INSERT, ID_NEG1, 63'd5,  1'b1, 6'd0);
        offer_command(sel_pkg::FUNC_READ,   '0,     '0,      1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_READ,   '0,     '0,      1'b0, 6'd4);
        offer_command(sel_pkg::FUNC_READ,   ID_MAX, KEY_MAX, 1'b1, 6'd63);
        // update moving down, moving up, and staying put
        offer_command(sel_pkg::FUNC_UPDATE, '0,      '0,      1'b1, 6'd0);
        offer_command(sel_pkg::FUNC_UPDATE, ID_MIN,  KEY_MAX, 1'b1, 6'd0);
        offer_command(sel_pkg::FUNC_UPDATE, ID_NEG1, 63'd5,   1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_REMOVE, '0,      '0,      1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_REMOVE, 64'd12345, '0,    1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_UPDATE, 64'd12345, 63'd9, 1'b1, 6'd0);
        offer_command(3'd5, ID_NEG1, KEY_MAX, 1'b1, 6'd63);
        offer_command(3'd6, '0,      '0,      1'b0, 6'd0);
        offer_command(3'd7, ID_MAX,  KEY_MAX, 1'b1, 6'd63);
        offer_command(sel_pkg::FUNC_CLEAR,  ID_NEG1, KEY_MAX, 1'b1, 6'd63);
        offer_command(sel_pkg::FUNC_READ,   '0,      '0,      1'b0, 6'd0);
        offer_command(sel_pkg::FUNC_INSERT, ID_NEG1, KEY_MAX, 1'b0, 6'd0);
        // full list and inserts refused
        fill_list();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 150)
                calm = 1'b1;
            if ($urandom_range(0, 9) < 2) begin
                fill_list();
            end else begin
                if ($urandom_range(0, 3) == 0)
                    offer_command(sel_pkg::FUNC_CLEAR, '0, '0, 1'b0, '0);
                repeat ($urandom_range(20, 60)) random_command();
            end
        end
        s_valid <= 1'b0;

        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d commands, %0d fill-to-capacity rounds, one long output stall",
                 items_sent, fill_rounds);
        $display("results: %0d ok, %0d id or row missing, %0d refused on a full list",
                 ok_seen, absent_seen, full_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
